// ===== hdl/kst_pkg.sv =====
package kst_pkg;

    // Command codes carried in the request
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2
    } cmd_t;

    // Status codes returned in the response
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_FINISH = 2'd2
    } state_t;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 8;
    localparam int SLOT_W = 8;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] value_out;
    } rsp_t;

    // Contents of one slot of the ring
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
    } entry_t;

    // Ring control from the sequencer to every cell
    typedef struct packed {
        logic shift;
        logic wr_en;
    } ring_ctl_t;

endpackage

// ===== hdl/kst_stream_if.sv =====
interface kst_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/kst_cell.sv =====
module kst_cell
    import kst_pkg::*;
#(
    parameter int IDX_W = 8,
    parameter int INDEX = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ring_ctl_t        ctl,
    input  logic [IDX_W-1:0] wr_idx,
    input  entry_t           wr_entry,
    input  entry_t           shift_in,
    output entry_t           entry
);

    logic                    valid_reg;
    logic                    valid_next;
    logic [KEY_W-1:0]        key_reg;
    logic [KEY_W-1:0]        key_next;
    logic [DATA_W-1:0]       value_reg;
    logic [DATA_W-1:0]       value_next;
    logic                    wr_hit;

    assign wr_hit = ctl.wr_en && (wr_idx == IDX_W'(INDEX));

    // Take the neighbor's entry on shift, or the new entry on a write here
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        if (ctl.shift)
        begin
            valid_next = shift_in.valid;
            key_next   = shift_in.key;
            value_next = shift_in.value;
        end
        else if (wr_hit)
        begin
            valid_next = wr_entry.valid;
            key_next   = wr_entry.key;
            value_next = wr_entry.value;
        end
    end

    // Valid mark clears at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Key and data hold no reset
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;

endmodule

// ===== hdl/kst_ctrl.sv =====
module kst_ctrl
    import kst_pkg::*;
#(
    parameter int SLOTS = 256,
    parameter int IDX_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    kst_stream_if.sink       req,
    kst_stream_if.source     rsp,
    input  entry_t           head,
    output entry_t           feed,
    output ring_ctl_t        ctl,
    output logic [IDX_W-1:0] wr_idx,
    output entry_t           wr_entry
);

    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

    state_t              state_reg;
    state_t              state_next;
    logic [IDX_W-1:0]    cnt_reg;
    logic [IDX_W-1:0]    cnt_next;
    logic [1:0]          cmd_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [DATA_W-1:0]   value_reg;
    logic                hit_reg;
    logic                hit_next;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic [IDX_W-1:0]    hit_idx_next;
    logic [DATA_W-1:0]   hit_val_reg;
    logic [DATA_W-1:0]   hit_val_next;
    logic                free_reg;
    logic                free_next;
    logic [IDX_W-1:0]    free_idx_reg;
    logic [IDX_W-1:0]    free_idx_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    rsp_t                rsp_reg;
    rsp_t                rsp_next;
    logic                req_fire;
    logic                out_free;
    logic                head_match;
    logic                head_empty;
    logic                is_insert;
    logic                is_lookup;

    assign req_fire   = req.valid && req.ready;
    assign out_free   = !rsp_valid_reg || rsp.ready;
    assign head_match = head.valid && (head.key == key_reg) && !hit_reg;
    assign head_empty = !head.valid && !free_reg;
    assign is_insert  = (cmd_reg == CMD_INSERT);
    assign is_lookup  = (cmd_reg == CMD_SEARCH) || (cmd_reg == CMD_DELETE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == LAST)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and scan datapath
    always_comb
    begin
        req.ready      = 1'b0;
        ctl.shift      = 1'b0;
        ctl.wr_en      = 1'b0;
        cnt_next       = cnt_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_val_next   = hit_val_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_next       = rsp_reg;
        feed           = head;
        unique case (state_reg)
            S_IDLE:
            begin
                req.ready     = 1'b1;
                cnt_next      = '0;
                hit_next      = 1'b0;
                free_next     = 1'b0;
            end
            S_SCAN:
            begin
                ctl.shift = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                // Record the first key match and the first empty slot
                if (head_match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cnt_reg;
                    hit_val_next = head.value;
                    // Drop the matching entry on delete as it passes the head
                    if (cmd_reg == CMD_DELETE)
                    begin
                        feed.valid = 1'b0;
                    end
                end
                if (head_empty)
                begin
                    free_next     = 1'b1;
                    free_idx_next = cnt_reg;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.status    = STAT_MISS;
                    rsp_next.slot      = '0;
                    rsp_next.value_out = '0;
                    if (is_insert)
                    begin
                        if (!hit_reg && free_reg)
                        begin
                            ctl.wr_en       = 1'b1;
                            rsp_next.status = STAT_OK;
                            rsp_next.slot   = SLOT_W'(free_idx_reg);
                        end
                        else if (!hit_reg)
                        begin
                            rsp_next.status = STAT_FULL;
                        end
                    end
                    else if (is_lookup && hit_reg)
                    begin
                        rsp_next.status    = STAT_OK;
                        rsp_next.slot      = SLOT_W'(hit_idx_reg);
                        rsp_next.value_out = hit_val_reg;
                    end
                end
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign wr_idx         = free_idx_reg;
    assign wr_entry.valid = 1'b1;
    assign wr_entry.key   = key_reg;
    assign wr_entry.value = value_reg;

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            cnt_reg       <= cnt_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg   <= req.payload.cmd;
            key_reg   <= req.payload.key;
            value_reg <= req.payload.value;
        end
        hit_idx_reg  <= hit_idx_next;
        hit_val_reg  <= hit_val_next;
        free_idx_reg <= free_idx_next;
        rsp_reg      <= rsp_next;
    end

    // An accepted request starts the scan at slot zero
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == S_SCAN) && (cnt_reg == '0))
        else $error("scan did not start at slot zero");

    // The scan ends only after the last slot went past the head
    a_scan_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) && ($past(state_reg) == S_SCAN)
            |-> ($past(cnt_reg) == LAST))
        else $error("scan ended early");

    // A match found during a scan is kept to its end
    a_hit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && hit_reg |=> hit_reg)
        else $error("match lost during scan");

    // A response appears only when a command finishes
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_FINISH))
        else $error("response without finished command");

endmodule

// ===== hdl/keyed_slot_table_top.sv =====
// Keyed slot table: SLOTS entries of (key, data), each with a valid mark.
// Request channel (req): cmd (insert, search, delete), key, value.
// Response channel (rsp): status, slot, value_out; one response per request.
// Both channels complete a transfer when valid and ready are high at a clock.
// The entries sit in a ring of cells that rotates one place per cycle, while
// a command scans, past a single key comparator in the sequencer. A command
// makes one full turn of the ring, noting the first match and the first free
// slot; a delete clears the matching entry as it passes the head, and an
// insert writes its slot in the finishing state after the turn.
// The response is registered in the finishing state, after the full turn.
// A new command waits until the previous one has finished its turn of
// the ring; req.ready is high only between commands.
// A finished response waits in an output register; a new request may be
// taken while it waits, and if rsp stays stalled the next command holds in
// its finishing cycle until the register frees.
// Reset clears every valid mark at once (table empty), no clearing pass.
module keyed_slot_table_top
    import kst_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    kst_stream_if.sink   req,
    kst_stream_if.source rsp
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    entry_t            cell_out [SLOTS];
    entry_t            feed;
    entry_t            wr_entry;
    ring_ctl_t         ctl;
    logic [IDX_W-1:0]  wr_idx;

    kst_ctrl #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .head     (cell_out[0]),
        .feed     (feed),
        .ctl      (ctl),
        .wr_idx   (wr_idx),
        .wr_entry (wr_entry)
    );

    // Ring of cells: each takes its upper neighbor, the last takes the head feed
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        entry_t shift_in;
        if (i == SLOTS - 1)
        begin : g_tail
            assign shift_in = feed;
        end
        else
        begin : g_link
            assign shift_in = cell_out[i+1];
        end

        kst_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .wr_idx   (wr_idx),
            .wr_entry (wr_entry),
            .shift_in (shift_in),
            .entry    (cell_out[i])
        );
    end

endmodule

// ===== dv/keyed_slot_table_top_tb.sv =====
module keyed_slot_table_top_tb;
    import kst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 256;
    localparam int CMD_TURN = SLOTS + 2;
    localparam int STALL_LIMIT = 20 * CMD_TURN;
    localparam int HOLD_CYCLES = 4 * CMD_TURN;
    localparam int POOL_SIZE = 16;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    kst_stream_if #(.payload_t(req_t)) req_if ();
    kst_stream_if #(.payload_t(rsp_t)) rsp_if ();

    keyed_slot_table_top #(
        .SLOTS(SLOTS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the table contents
    logic              tab_valid [SLOTS];
    logic [KEY_W-1:0]  tab_key   [SLOTS];
    logic [DATA_W-1:0] tab_value [SLOTS];

    req_t        pending_cmds [$];
    rsp_t        expected_rsps [$];
    rsp_t        oldest_rsp;
    logic [31:0] key_pool [POOL_SIZE];
    logic [31:0] fill_keys [$];

    int  mismatches;
    int  requests_taken;
    int  quiet_cycles;
    int  idle_pct;
    bit  req_taken;
    bit  rsp_hold;

    // Apply one request to the shadow table and return the response it gives
    function automatic rsp_t apply_command(req_t r);
        rsp_t o;
        int   hit;
        int   free_slot;
        o.status    = STAT_MISS;
        o.slot      = '0;
        o.value_out = '0;
        hit         = -1;
        free_slot   = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (hit < 0 && tab_valid[i] && tab_key[i] == r.key)
                hit = i;
            if (free_slot < 0 && !tab_valid[i])
                free_slot = i;
        end
        case (r.cmd)
            CMD_INSERT:
            begin
                if (hit < 0)
                begin
                    if (free_slot >= 0)
                    begin
                        tab_valid[free_slot] = 1'b1;
                        tab_key[free_slot]   = r.key;
                        tab_value[free_slot] = r.value;
                        o.status             = STAT_OK;
                        o.slot               = SLOT_W'(free_slot);
                    end
                    else
                    begin
                        o.status = STAT_FULL;
                    end
                end
            end
            CMD_SEARCH, CMD_DELETE:
            begin
                if (hit >= 0)
                begin
                    o.status    = STAT_OK;
                    o.slot      = SLOT_W'(hit);
                    o.value_out = tab_value[hit];
                    if (r.cmd == CMD_DELETE)
                        tab_valid[hit] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    task automatic queue_cmd(logic [1:0] c, logic [31:0] k, logic [7:0] v);
        req_t r;
        r.cmd   = c;
        r.key   = k;
        r.value = v;
        pending_cmds.push_back(r);
    endtask

    // Hold until every queued request is taken and every response is back
    task automatic drain_all();
        while (pending_cmds.size() != 0 || req_if.valid || expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
    end

    // Request driver: advance to the next request once the current one is taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
        end
        else if (!req_if.valid || req_taken)
        begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                req_if.valid   <= 1'b1;
                req_if.payload <= pending_cmds.pop_front();
            end
            else
            begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Response sink: random stalls, plus the long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
            rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= idle_pct);
    end

    // Hold off responses for a long stretch so the block backs up its input
    initial
    begin
        rsp_hold = 1'b0;
        while (requests_taken < 30)
            @(posedge clk);
        rsp_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold = 1'b0;
    end

    // Monitor: predict on each taken request, check each response
    always @(posedge clk)
    begin
        req_taken = rst_n && req_if.valid && req_if.ready;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("response with no request pending: status %0d slot %0d value_out %0d",
                       rsp_if.payload.status, rsp_if.payload.slot,
                       rsp_if.payload.value_out);
                mismatches++;
            end
            else
            begin
                oldest_rsp = expected_rsps.pop_front();
                if (rsp_if.payload.status !== oldest_rsp.status)
                begin
                    $error("status: expected %0d, got %0d",
                           oldest_rsp.status, rsp_if.payload.status);
                    mismatches++;
                end
                if (rsp_if.payload.slot !== oldest_rsp.slot)
                begin
                    $error("slot: expected %0d, got %0d",
                           oldest_rsp.slot, rsp_if.payload.slot);
                    mismatches++;
                end
                if (rsp_if.payload.value_out !== oldest_rsp.value_out)
                begin
                    $error("value_out: expected %0d, got %0d",
                           oldest_rsp.value_out, rsp_if.payload.value_out);
                    mismatches++;
                end
            end
        end
        if (req_taken)
        begin
            expected_rsps.push_back(apply_command(req_if.payload));
            requests_taken++;
        end
    end

    // Watchdog: stop when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[keyed_slot_table_top] ERROR");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int pick;
        int idx;
        logic [31:0] fresh;

        mismatches     = 0;
        requests_taken = 0;
        quiet_cycles   = 0;
        idle_pct       = 13;
        req_taken      = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            tab_valid[i] = 1'b0;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        // Directed: empty table, extremes, duplicate, unused code, slot reuse
        queue_cmd(CMD_SEARCH, 32'h0000_0000, 8'h00);
        queue_cmd(CMD_DELETE, 32'hFFFF_FFFF, 8'hFF);
        queue_cmd(CMD_INSERT, 32'h0000_0000, 8'h00);
        queue_cmd(CMD_INSERT, 32'hFFFF_FFFF, 8'hFF);
        queue_cmd(CMD_INSERT, 32'h0000_0000, 8'h55);
        queue_cmd(CMD_SEARCH, 32'hFFFF_FFFF, 8'h00);
        queue_cmd(CMD_SEARCH, 32'h0000_0000, 8'hFF);
        queue_cmd(CMD_UNUSED, 32'h0000_0000, 8'hAA);
        queue_cmd(CMD_SEARCH, 32'h0000_0000, 8'h00);
        queue_cmd(CMD_DELETE, 32'h0000_0000, 8'h00);
        queue_cmd(CMD_SEARCH, 32'h0000_0000, 8'h00);
        queue_cmd(CMD_INSERT, 32'h1234_5678, 8'hA5);
        queue_cmd(CMD_INSERT, 32'h0000_0000, 8'h5A);
        queue_cmd(CMD_DELETE, 32'hFFFF_FFFF, 8'h00);
        queue_cmd(CMD_DELETE, 32'hFFFF_FFFF, 8'h00);
        queue_cmd(CMD_INSERT, 32'h8000_0000, 8'h80);
        queue_cmd(CMD_SEARCH, 32'h8000_0000, 8'h00);
        queue_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF);

        // Sender pause until every response is back
        while (rst_n !== 1'b1)
            @(posedge clk);
        drain_all();

        // Mixed traffic on a small key pool; the long response hold lands here
        for (int n = 0; n < 120; n++)
        begin
            idx = $urandom_range(POOL_SIZE - 1);
            if ($urandom_range(49) == 0)
                queue_cmd(CMD_UNUSED, key_pool[idx], 8'($urandom));
            else
                queue_cmd(2'($urandom_range(2)), key_pool[idx], 8'($urandom));
        end
        drain_all();

        // Fill the table to the top with fresh keys, no idling
        idle_pct = 0;
        for (int n = 0; n < SLOTS + 4; n++)
        begin
            fresh = $urandom;
            fill_keys.push_back(fresh);
            queue_cmd(CMD_INSERT, fresh, 8'($urandom));
        end
        drain_all();
        idle_pct = 13;

        // Churn on a full table: free and refill slots, duplicates, full inserts
        for (int n = 0; n < 120; n++)
        begin
            pick = $urandom_range(99);
            idx  = $urandom_range(fill_keys.size() - 1);
            if (pick < 30)
            begin
                queue_cmd(CMD_DELETE, fill_keys[idx], 8'($urandom));
                fresh = $urandom;
                fill_keys.push_back(fresh);
                queue_cmd(CMD_INSERT, fresh, 8'($urandom));
            end
            else if (pick < 55)
                queue_cmd(CMD_SEARCH, fill_keys[idx], 8'($urandom));
            else if (pick < 70)
                queue_cmd(CMD_INSERT, fill_keys[idx], 8'($urandom));
            else if (pick < 85)
                queue_cmd(CMD_INSERT, $urandom, 8'($urandom));
            else
                queue_cmd(2'($urandom_range(CMD_SEARCH, CMD_DELETE)), $urandom,
                          8'($urandom));
        end

        // Drain the table: mostly deletes of stored keys, some searches and noise
        for (int n = 0; n < 150; n++)
        begin
            pick = $urandom_range(99);
            idx  = $urandom_range(fill_keys.size() - 1);
            if (pick < 65)
                queue_cmd(CMD_DELETE, fill_keys[idx], 8'($urandom));
            else if (pick < 85)
                queue_cmd(CMD_SEARCH, fill_keys[idx], 8'($urandom));
            else if (pick < 95)
                queue_cmd(CMD_INSERT, $urandom, 8'($urandom));
            else
                queue_cmd(CMD_UNUSED, fill_keys[idx], 8'($urandom));
        end

        // Wait out the last responses, then report
        drain_all();
        repeat (CMD_TURN + 10) @(posedge clk);
        if (expected_rsps.size() != 0)
        begin
            $error("%0d responses never arrived", expected_rsps.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("[keyed_slot_table_top] OK");
        else
            $display("[keyed_slot_table_top] ERROR");
        $finish;
    end

endmodule
